>>> design/cfg_valset_frame_builder_top_macros.svh
// assertion macros for the configuration-set frame builder
// no dependencies; included by modules that carry concurrent checks
`ifndef CFG_VALSET_FRAME_BUILDER_TOP_MACROS_SVH
`define CFG_VALSET_FRAME_BUILDER_TOP_MACROS_SVH

// check that is switched off while reset is asserted
`define CVFB_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that also holds during reset
`define CVFB_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/cvfb_pkg.sv
// package for the configuration-set frame builder: frame constants, types, header byte lookup
// no dependencies
`timescale 1ns / 1ps

package cvfb_pkg;

  localparam logic [7:0] SYNC_A      = 8'hB5;
  localparam logic [7:0] SYNC_B      = 8'h62;
  localparam logic [7:0] CLASS_CFG   = 8'h06;
  localparam logic [7:0] MSG_ID      = 8'h8A;
  localparam logic [7:0] MSG_VERSION = 8'h01;
  localparam logic [7:0] LEN_BASE    = 8'd8;

  localparam int unsigned MAX_VAL_BYTES = 4;
  localparam int unsigned MAX_FRAME     = 20;
  localparam int unsigned IDX_W         = $clog2(MAX_FRAME);

  // byte positions inside the frame
  localparam logic [IDX_W-1:0] POS_SYNC_A  = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_SYNC_B  = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_CLASS   = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_ID      = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_LEN_LO  = IDX_W'(4);
  localparam logic [IDX_W-1:0] POS_LEN_HI  = IDX_W'(5);
  localparam logic [IDX_W-1:0] POS_VERSION = IDX_W'(6);
  localparam logic [IDX_W-1:0] POS_LAYER   = IDX_W'(7);
  localparam logic [IDX_W-1:0] POS_RSVD0   = IDX_W'(8);
  localparam logic [IDX_W-1:0] POS_RSVD1   = IDX_W'(9);
  localparam logic [IDX_W-1:0] POS_KEY0    = IDX_W'(10);
  localparam logic [IDX_W-1:0] POS_KEY1    = IDX_W'(11);
  localparam logic [IDX_W-1:0] POS_KEY2    = IDX_W'(12);
  localparam logic [IDX_W-1:0] POS_KEY3    = IDX_W'(13);
  localparam logic [IDX_W-1:0] POS_VALUE   = IDX_W'(14);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // controls for the checksum unit
  typedef struct packed {
    logic clear;
    logic add;
  } ck_ctrl_t;

  // fixed-layout header and key bytes, positions below the value field
  function automatic logic [7:0] hdr_byte(logic [IDX_W-1:0] idx, logic [7:0] layer,
                                          logic [31:0] key, logic [2:0] nval);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      POS_SYNC_A:  b = SYNC_A;
      POS_SYNC_B:  b = SYNC_B;
      POS_CLASS:   b = CLASS_CFG;
      POS_ID:      b = MSG_ID;
      POS_LEN_LO:  b = LEN_BASE + {5'b0, nval};
      POS_LEN_HI:  b = 8'h00;
      POS_VERSION: b = MSG_VERSION;
      POS_LAYER:   b = layer;
      POS_RSVD0:   b = 8'h00;
      POS_RSVD1:   b = 8'h00;
      POS_KEY0:    b = key[7:0];
      POS_KEY1:    b = key[15:8];
      POS_KEY2:    b = key[23:16];
      POS_KEY3:    b = key[31:24];
      default:     b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> design/cvfb_if.sv
// channel interfaces: request in, frame bytes out
// depends on nothing
`timescale 1ns / 1ps

interface cvfb_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] config_key;
  logic [31:0] config_value;
  logic [2:0]  value_bytes;
  logic [7:0]  layer_mask;

  modport source (output valid, config_key, config_value, value_bytes, layer_mask,
                  input ready);
  modport sink   (input valid, config_key, config_value, value_bytes, layer_mask,
                  output ready);
endinterface

interface cvfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

>>> design/cvfb_fletcher.sv
// 8-bit fletcher checksum accumulator, one byte per cycle while add is set
// depends on cvfb_pkg
`timescale 1ns / 1ps

module cvfb_fletcher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cvfb_pkg::ck_ctrl_t ctrl_i,
  input  logic [7:0]        data_i,
  output logic [7:0]        cka_o,
  output logic [7:0]        ckb_o
);
  import cvfb_pkg::*;

  logic [7:0] cka_q, cka_d;
  logic [7:0] ckb_q, ckb_d;

  always_comb begin
    cka_d = cka_q;
    ckb_d = ckb_q;
    if (ctrl_i.clear) begin
      cka_d = 8'h00;
      ckb_d = 8'h00;
    end else if (ctrl_i.add) begin
      cka_d = cka_q + data_i;
      ckb_d = ckb_q + cka_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cka_q <= 8'h00;
      ckb_q <= 8'h00;
    end else begin
      cka_q <= cka_d;
      ckb_q <= ckb_d;
    end
  end

  assign cka_o = cka_q;
  assign ckb_o = ckb_q;

endmodule

>>> design/cfg_valset_frame_builder_top.sv
// configuration-set frame builder, top level
// depends on cvfb_pkg, cvfb_if, cvfb_fletcher and the assertion macro header
`timescale 1ns / 1ps
`include "cfg_valset_frame_builder_top_macros.svh"

// One request (key, value, value byte count, layer mask) becomes one binary
// configuration-set frame, sent one byte per transaction on frm_o: two sync bytes,
// class, id, little-endian length (8 plus the value byte count), version, layer mask,
// two reserved zeros, four key bytes, the low value bytes, then the two fletcher
// checksum bytes taken over class through payload. A value byte count of 0 sends no
// value bytes, counts of 5 to 7 are treated as 4, so a frame is 16 to 20 bytes long and
// last_byte marks its final checksum byte. The request port takes a transaction only
// while no frame is being built, so the next request waits until the final byte has
// entered the output register. The byte sequencer advances one position per cycle while
// the output register is empty or being drained, and feeds every summed byte through a
// single shared checksum adder pair. The output register lets the next request be
// taken while the final byte is still waiting for the sink.
module cfg_valset_frame_builder_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  cvfb_req_if.sink    req_i,
  cvfb_byte_if.source frm_o
);
  import cvfb_pkg::*;

  state_e state_q, state_d;

  // byte position counter
  logic [IDX_W-1:0] idx_q, idx_d;

  // latched request
  logic [31:0] key_q;
  logic [31:0] val_q;
  logic [2:0]  nval_q;
  logic [7:0]  layer_q;
  logic [2:0]  nval_sat;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic             req_take;
  logic             load;
  logic [IDX_W-1:0] cka_idx;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] val_off;
  logic             summed;
  logic [7:0]       next_byte;
  logic             next_last;
  logic [7:0]       cka;
  logic [7:0]       ckb;
  ck_ctrl_t         ck_ctrl;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_take    = req_i.valid && req_i.ready;

  // counts above four saturate, only 32 value bits exist
  assign nval_sat = (req_i.value_bytes > 3'(MAX_VAL_BYTES)) ?
                    3'(MAX_VAL_BYTES) : req_i.value_bytes;

  // a new byte enters the output register when it is empty or being drained
  assign load = (state_q == ST_RUN) && (!out_valid_q || frm_o.ready);

  assign cka_idx  = POS_VALUE + IDX_W'(nval_q);
  assign last_idx = cka_idx + IDX_W'(1);
  assign val_off  = idx_q - POS_VALUE;

  // class through end of payload goes into the checksum
  assign summed = (idx_q >= POS_CLASS) && (idx_q < cka_idx);

  // byte selection for the current position
  always_comb begin
    if (idx_q < POS_VALUE) begin
      next_byte = hdr_byte(idx_q, layer_q, key_q, nval_q);
    end else if (idx_q < cka_idx) begin
      next_byte = val_q[{val_off[1:0], 3'b000} +: 8];
    end else if (idx_q == cka_idx) begin
      next_byte = cka;
    end else begin
      next_byte = ckb;
    end
    next_last = (idx_q == last_idx);
  end

  assign ck_ctrl.clear = req_take;
  assign ck_ctrl.add   = load && summed;

  cvfb_fletcher u_fletcher (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ck_ctrl),
    .data_i (next_byte),
    .cka_o  (cka),
    .ckb_o  (ckb)
  );

  // sequencer: next state and counter
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (frm_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (req_take) begin
          state_d = ST_RUN;
          idx_d   = '0;
        end
      end
      ST_RUN: begin
        if (load) begin
          out_valid_d = 1'b1;
          idx_d       = idx_q + IDX_W'(1);
          if (next_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      key_q   <= req_i.config_key;
      val_q   <= req_i.config_value;
      nval_q  <= nval_sat;
      layer_q <= req_i.layer_mask;
    end
    if (load) begin
      out_byte_q <= next_byte;
      out_last_q <= next_last;
    end
  end

  assign frm_o.valid      = out_valid_q;
  assign frm_o.frame_byte = out_byte_q;
  assign frm_o.last_byte  = out_last_q;

  // a taken request starts a frame at its first position
  `CVFB_ASSERT(a_req_starts_frame, clk_i, rst_ni,
               req_take |=> (state_q == ST_RUN) && (idx_q == '0), "frame did not start")
  // the final byte ends the frame
  `CVFB_ASSERT(a_last_ends_frame, clk_i, rst_ni,
               (load && next_last) |=> (state_q == ST_IDLE), "frame ran past last byte")
  // the position never passes the last checksum byte
  `CVFB_ASSERT(a_idx_in_range, clk_i, rst_ni,
               (state_q == ST_RUN) |-> (idx_q <= last_idx), "byte position out of range")
  // the first byte loaded is the first sync byte
  `CVFB_ASSERT(a_first_sync, clk_i, rst_ni,
               (load && (idx_q == POS_SYNC_A)) |=> (frm_o.frame_byte == SYNC_A),
               "frame does not open with sync")

endmodule
